// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the u8sd_checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Widths, lead byte ranges and the record passed between decoder modules.
// ----------------------------------------------------------------------------
package u8sd_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int PEND_W = 2;

	localparam logic [BYTE_W-1:0] ASCII_LO = 8'h00;
	localparam logic [BYTE_W-1:0] ASCII_HI = 8'h7F;
	localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF7;

	localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
	localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
	localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
	localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

	typedef struct packed {
		logic [PEND_W-1:0] pending;
		logic [CP_W-1:0]   partial;
	} dec_state_t;

	typedef struct packed {
		logic            valid;
		logic [CP_W-1:0] code_point;
		logic            bad_lead;
	} dec_result_t;

endpackage

// ===== hw/rtl/utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into code points, flagging unrecognised lead bytes.
// ----------------------------------------------------------------------------
//  Channel      Handshake                Payload
//  byte input   byte_valid / byte_stall  in_byte
//  code output  cp_valid / cp_stall      code_point, bad_lead
//
// One byte is taken every cycle unless byte_stall holds it; the byte that
// completes a result passes through the input register and the result register.
// The decoder state updates as a byte leaves the input register.
// Reset clears the sequence state and both valid flags.
// A stall on the output stalls the input only when the byte held next would
// produce a result while the result register is still occupied.
module utf8_stream_decoder_top import u8sd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              cp_valid,
	input  logic              cp_stall,
	output logic [CP_W-1:0]   code_point,
	output logic              bad_lead
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	dec_state_t        state_q;
	dec_state_t        state_nxt;
	dec_result_t       res;
	logic              out_valid_q;
	logic [CP_W-1:0]   cp_q;
	logic              bad_q;
	logic              out_free;
	logic              advance;

	u8sd_decode u_decode (
		.in_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	assign out_free   = !out_valid_q || !cp_stall;
	assign advance    = valid_s1 && (!res.valid || out_free);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res.valid) begin
			cp_q  <= res.code_point;
			bad_q <= res.bad_lead;
		end
	end

	assign cp_valid   = out_valid_q;
	assign code_point = cp_q;
	assign bad_lead   = bad_q;

endmodule

// ===== hw/rtl/u8sd_decode.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Combinational next-state and result logic for one byte of the stream.
// ----------------------------------------------------------------------------
module u8sd_decode import u8sd_pkg::*; (
	input  logic [BYTE_W-1:0] in_byte,
	input  dec_state_t        cur,
	output dec_state_t        nxt,
	output dec_result_t       res
);

	logic [CP_W-1:0]   acc;
	logic [PEND_W-1:0] pend_dec;

	assign acc      = {cur.partial[CP_W-7:0], in_byte[5:0]};
	assign pend_dec = cur.pending - PEND_ONE;

	always_comb begin
		nxt = cur;
		res = '0;
		if (cur.pending != PEND_NONE) begin
			nxt.pending = pend_dec;
			if (pend_dec == PEND_NONE) begin
				nxt.partial    = '0;
				res.valid      = 1'b1;
				res.code_point = acc;
			end else begin
				nxt.partial = acc;
			end
		end else begin
			case (in_byte) inside
				[ASCII_LO:ASCII_HI]: begin
					res.valid      = 1'b1;
					res.code_point = CP_W'(in_byte);
				end
				[LEAD2_LO:LEAD2_HI]: begin
					nxt.pending = PEND_ONE;
					nxt.partial = CP_W'(in_byte[4:0]);
				end
				[LEAD3_LO:LEAD3_HI]: begin
					nxt.pending = PEND_TWO;
					nxt.partial = CP_W'(in_byte[3:0]);
				end
				[LEAD4_LO:LEAD4_HI]: begin
					nxt.pending = PEND_THREE;
					nxt.partial = CP_W'(in_byte[2:0]);
				end
				default: begin
					nxt.partial  = '0;
					res.valid    = 1'b1;
					res.bad_lead = 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/u8sd_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8sd_checker import u8sd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              byte_valid,
	input logic              byte_stall,
	input logic              cp_valid,
	input logic              cp_stall,
	input logic [CP_W-1:0]   code_point,
	input logic              bad_lead
);

	// An invalid lead byte always reports a zero code point.
	`ASSERT_SAME(a_bad_zero, clk, arst_n, cp_valid && bad_lead, code_point == '0,
		"bad lead with non-zero code point")

	// The input is held back only while a finished result is itself held back.
	`ASSERT_SAME(a_stall_cause, clk, arst_n, byte_stall, cp_valid && cp_stall,
		"input stalled without output back-pressure")

	// A stalled result transaction keeps its payload.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, cp_valid && cp_stall,
		cp_valid && $stable(code_point) && $stable(bad_lead), "stalled result changed")

	// With no byte offered or held upstream of the result register, none can appear.
	`ASSERT_SAME(a_no_phantom, clk, arst_n,
		!$past(byte_valid) && !$past(byte_valid, 2) &&
		!$past(cp_valid) && !$past(byte_stall, 2),
		!cp_valid, "result without a source transaction")

endmodule

bind utf8_stream_decoder_top u8sd_checker u_u8sd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.cp_valid   (cp_valid),
	.cp_stall   (cp_stall),
	.code_point (code_point),
	.bad_lead   (bad_lead)
);

// ===== test/utf8_stream_decoder_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Watches the byte and code point channels of the decoder. A prediction of
// the lax decoding is built from every accepted byte, and each accepted code
// point transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_checker import u8sd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic              byte_stall,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              cp_valid,
	input  logic              cp_stall,
	input  logic [CP_W-1:0]   code_point,
	input  logic              bad_lead,
	output int                error_count,
	output int                expected_left,
	output int                results_checked,
	output int                bad_leads_checked
);

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            bad_lead;
	} cp_result_t;

	cp_result_t        cp_due_q[$];
	cp_result_t        oldest;
	logic [PEND_W-1:0] follow_left;
	logic [CP_W-1:0]   cp_accum;

	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		cp_result_t r;
		r = '0;
		if (follow_left != PEND_NONE) begin
			cp_accum = {cp_accum[CP_W-7:0], b[5:0]};
			follow_left = follow_left - 1'b1;
			if (follow_left == PEND_NONE) begin
				r.code_point = cp_accum;
				cp_due_q.push_back(r);
				cp_accum = '0;
			end
		end else if (b <= ASCII_HI) begin
			r.code_point = CP_W'(b);
			cp_due_q.push_back(r);
		end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			cp_accum = CP_W'(b[4:0]);
			follow_left = PEND_ONE;
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			cp_accum = CP_W'(b[3:0]);
			follow_left = PEND_TWO;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			cp_accum = CP_W'(b[2:0]);
			follow_left = PEND_THREE;
		end else begin
			cp_accum = '0;
			r.bad_lead = 1'b1;
			cp_due_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_due_q.delete();
			follow_left = PEND_NONE;
			cp_accum = '0;
			error_count = 0;
			expected_left = 0;
			results_checked = 0;
			bad_leads_checked = 0;
		end else begin
			if (cp_valid && !cp_stall) begin
				if (cp_due_q.size() == 0) begin
					$error("Unexpected code point transaction: code_point %h, bad_lead %b",
						code_point, bad_lead);
					error_count++;
				end else begin
					oldest = cp_due_q.pop_front();
					if (code_point !== oldest.code_point) begin
						$error("Field code_point: expected %h, actual %h",
							oldest.code_point, code_point);
						error_count++;
					end
					if (bad_lead !== oldest.bad_lead) begin
						$error("Field bad_lead: expected %b, actual %b",
							oldest.bad_lead, bad_lead);
						error_count++;
					end
					results_checked++;
					if (oldest.bad_lead)
						bad_leads_checked++;
				end
			end
			if (byte_valid && !byte_stall)
				decode_byte(in_byte);
			expected_left = cp_due_q.size();
		end
	end

endmodule

// ===== test/tb_utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Feeds a directed set of byte sequences followed by random, mostly well
// formed UTF-8 traffic in bursts, while the result side stalls on changing
// patterns and at set points holds off long enough to back up the input. Checking is
// left to the checker module; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_top;
	import u8sd_pkg::*;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_e;

	logic              clk;
	logic              arst_n;
	logic              byte_valid;
	logic              byte_stall;
	logic [BYTE_W-1:0] in_byte;
	logic              cp_valid;
	logic              cp_stall;
	logic [CP_W-1:0]   code_point;
	logic              bad_lead;

	int error_count;
	int expected_left;
	int results_checked;
	int bad_leads_checked;

	logic [BYTE_W-1:0] byte_stream_q[$];

	logic [BYTE_W-1:0] directed_bytes [25] = '{
		8'h00, 8'h7F,
		8'hC0, 8'h80,
		8'hDF, 8'hBF,
		8'hE0, 8'h80, 8'h80,
		8'hF0, 8'h80, 8'h80, 8'h80,
		8'hF7, 8'hBF, 8'hBF, 8'hBF,
		8'h80, 8'hF8, 8'hFF,
		8'hC3, 8'h41,
		8'hE2, 8'hFF, 8'hC0
	};

	utf8_stream_decoder_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.in_byte    (in_byte),
		.cp_valid   (cp_valid),
		.cp_stall   (cp_stall),
		.code_point (code_point),
		.bad_lead   (bad_lead)
	);

	utf8_stream_decoder_checker checker_i (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_valid        (byte_valid),
		.byte_stall        (byte_stall),
		.in_byte           (in_byte),
		.cp_valid          (cp_valid),
		.cp_stall          (cp_stall),
		.code_point        (code_point),
		.bad_lead          (bad_lead),
		.error_count       (error_count),
		.expected_left     (expected_left),
		.results_checked   (results_checked),
		.bad_leads_checked (bad_leads_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [BYTE_W-1:0] follow_byte();
		if ($urandom_range(0, 9) != 0)
			return 8'h80 | BYTE_W'($urandom_range(0, 63));
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic add_sequence(input logic [BYTE_W-1:0] lead, input int n_follow);
		byte_stream_q.push_back(lead);
		repeat (n_follow)
			byte_stream_q.push_back(follow_byte());
	endtask

	task automatic build_random(input int target);
		int kind;
		while (byte_stream_q.size() < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 25)
				byte_stream_q.push_back(BYTE_W'($urandom_range(0, 127)));
			else if (kind < 45)
				add_sequence(LEAD2_LO + BYTE_W'($urandom_range(0, 31)), 1);
			else if (kind < 65)
				add_sequence(LEAD3_LO + BYTE_W'($urandom_range(0, 15)), 2);
			else if (kind < 80)
				add_sequence(LEAD4_LO + BYTE_W'($urandom_range(0, 7)), 3);
			else if (kind < 88)
				byte_stream_q.push_back($urandom_range(0, 1) ?
					8'h80 + BYTE_W'($urandom_range(0, 63)) :
					8'hF8 + BYTE_W'($urandom_range(0, 7)));
			else begin
				byte_stream_q.push_back(LEAD2_LO + BYTE_W'($urandom_range(0, 55)));
				repeat ($urandom_range(0, 3))
					byte_stream_q.push_back(BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic send_stream();
		int burst_left;
		int gap;
		burst_left = 0;
		foreach (byte_stream_q[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 5);
				if (gap != 0) begin
					byte_valid = 1'b0;
					in_byte = BYTE_W'($urandom_range(0, 255));
					repeat (gap) @(negedge clk);
				end
			end
			byte_valid = 1'b1;
			in_byte = byte_stream_q[i];
			do @(posedge clk); while (byte_stall);
			@(negedge clk);
			burst_left--;
		end
		byte_valid = 1'b0;
	endtask

	initial begin
		int cycle;
		int hold_left;
		stall_mode_e mode;
		cycle = 0;
		hold_left = 0;
		mode = STALL_NONE;
		cp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycle++;
			if (hold_left == 0 && cycle % 2500 == 1200)
				hold_left = 120;
			if (hold_left > 0) begin
				cp_stall = 1'b1;
				hold_left--;
			end else begin
				if (cycle % 300 == 0)
					mode = stall_mode_e'($urandom_range(0, 3));
				case (mode)
					STALL_NONE:     cp_stall = 1'b0;
					STALL_LIGHT:    cp_stall = ($urandom_range(0, 99) < 30);
					STALL_HEAVY:    cp_stall = ($urandom_range(0, 99) < 75);
					STALL_PERIODIC: cp_stall = (cycle % 5 < 2);
					default:        cp_stall = 1'b0;
				endcase
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		in_byte = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed_bytes[i])
			byte_stream_q.push_back(directed_bytes[i]);
		build_random(1850);
		send_stream();
		while (expected_left != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("Sent %0d bytes and checked %0d code points, %0d of them bad leads.",
			byte_stream_q.size(), results_checked, bad_leads_checked);
		$display("Covered ASCII, two- to four-byte, overlong, out-of-range, bad lead and "
			, "broken sequences under bursty input and output back-pressure.");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#3000000;
		$display("Timeout: the run did not drain in time.");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
